FILE: sv/sln_pkg.sv
// Shared types, constants and helpers for the script line normaliser.
package sln_pkg;

  localparam int LINE_BUFFER = 1024;
  localparam int COUNT_W     = $clog2(LINE_BUFFER);
  localparam int RUN_W       = 10;
  localparam int CHAR_W      = 8;
  localparam int NSLOT       = 3;
  localparam int SLOT_W      = 2;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LINE_BUFFER - 2);
  localparam logic [RUN_W-1:0]   SPACE_MAX   = '1;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_EOL  = 2'd1,
    KIND_EOT  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [RUN_W-1:0]   run;
    logic [CHAR_W-1:0]  ch;
  } res_t;

  // Up to three results caused by one input byte.
  typedef struct packed {
    logic [SLOT_W-1:0]   count;
    res_t [NSLOT-1:0]    slot;
  } burst_t;

  function automatic burst_t put_res(burst_t b, kind_e k, logic [RUN_W-1:0] r,
                                     logic [CHAR_W-1:0] c);
    res_t   e;
    burst_t o;
    e.kind = k;
    e.run  = r;
    e.ch   = c;
    o      = b;
    unique case (b.count)
      2'd0: begin
        o.slot[0] = e;
        o.count   = 2'd1;
      end
      2'd1: begin
        o.slot[1] = e;
        o.count   = 2'd2;
      end
      2'd2: begin
        o.slot[2] = e;
        o.count   = 2'd3;
      end
      default: begin
        o = b;
      end
    endcase
    return o;
  endfunction

endpackage

FILE: sv/sln_front.sv
// Front end: takes text bytes, tracks line state and builds result bursts.
module sln_front
  import sln_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [CHAR_W-1:0]   in_byte_i,
  output logic                push_o,
  output burst_t              burst_o
);

  typedef struct packed {
    logic                at_start;
    logic [COUNT_W-1:0]  count;
    logic                in_comment;
    logic                slash;
    logic [RUN_W-1:0]    spaces;
    logic                has_content;
  } st_t;

  localparam st_t ST_RESET = '{at_start: 1'b1, count: '0, in_comment: 1'b0,
                               slash: 1'b0, spaces: '0, has_content: 1'b0};

  st_t                st_q, st_d;
  burst_t             burst_d;
  logic [CHAR_W-1:0]  ch_c;
  logic               taken_c;
  logic               end_c;
  logic               accept;

  assign accept = in_valid_i && in_ready_i;

  always_comb begin
    st_d    = st_q;
    burst_d = '0;
    ch_c    = (in_byte_i == CH_TAB) ? CH_SPACE : in_byte_i;
    taken_c = 1'b0;
    end_c   = 1'b0;

    if (st_q.at_start && (in_byte_i == CH_NUL)) begin
      burst_d = put_res(burst_d, KIND_EOT, '0, '0);
      st_d    = ST_RESET;
    end else if (st_q.at_start && (in_byte_i <= CH_SPACE)) begin
      st_d = st_q;
    end else if (st_q.at_start &&
                 ((in_byte_i == CH_LBRACE) || (in_byte_i == CH_RBRACE))) begin
      // brace at line start stands as a line of its own
      burst_d = put_res(burst_d, KIND_CHAR, '0, in_byte_i);
      burst_d = put_res(burst_d, KIND_EOL, '0, '0);
    end else begin
      st_d.at_start = 1'b0;
      if ((in_byte_i == CH_NUL) || (in_byte_i == CH_CR) || (in_byte_i == CH_LF)) begin
        end_c = 1'b1;
      end else begin
        st_d.count = st_q.count + COUNT_W'(1);
        if (!st_q.in_comment) begin
          if (st_q.slash) begin
            st_d.slash = 1'b0;
            if (ch_c == CH_SLASH) begin
              st_d.in_comment = 1'b1;
              taken_c         = 1'b1;
            end else begin
              burst_d          = put_res(burst_d, KIND_CHAR, st_d.spaces, CH_SLASH);
              st_d.spaces      = '0;
              st_d.has_content = 1'b1;
            end
          end
          if (!taken_c) begin
            if (ch_c == CH_SPACE) begin
              if (st_d.has_content && (st_d.spaces != SPACE_MAX)) begin
                st_d.spaces = st_d.spaces + RUN_W'(1);
              end
            end else if (ch_c == CH_SLASH) begin
              st_d.slash = 1'b1;
            end else begin
              burst_d          = put_res(burst_d, KIND_CHAR, st_d.spaces, ch_c);
              st_d.spaces      = '0;
              st_d.has_content = 1'b1;
            end
          end
        end
        if (st_d.count >= COUNT_LIMIT) begin
          end_c = 1'b1;
        end
      end

      if (end_c) begin
        // a lone held slash is a plain character at line end
        if (st_d.slash && !st_d.in_comment) begin
          burst_d          = put_res(burst_d, KIND_CHAR, st_d.spaces, CH_SLASH);
          st_d.has_content = 1'b1;
        end
        if (st_d.has_content) begin
          burst_d       = put_res(burst_d, KIND_EOL, '0, '0);
          st_d.at_start = 1'b1;
        end
        st_d.count       = '0;
        st_d.in_comment  = 1'b0;
        st_d.slash       = 1'b0;
        st_d.spaces      = '0;
        st_d.has_content = 1'b0;
      end

      if (in_byte_i == CH_NUL) begin
        burst_d = put_res(burst_d, KIND_EOT, '0, '0);
        st_d    = ST_RESET;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RESET;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  assign push_o  = accept && (burst_d.count != '0);
  assign burst_o = burst_d;

endmodule

FILE: sv/sln_queue.sv
// Small burst queue between the front end and the output sequencer.
module sln_queue
  import sln_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  burst_t  burst_i,
  output logic    full_o,
  input  logic    pop_i,
  output burst_t  head_o,
  output logic    empty_o
);

  burst_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QPTR_W:0]    fill_q;

  assign full_o  = (fill_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= burst_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + (QPTR_W+1)'(1);
        2'b01:   fill_q <= fill_q - (QPTR_W+1)'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

FILE: sv/sln_back.sv
// Output sequencer: sends the results of the head burst one per transfer.
module sln_back
  import sln_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  burst_t               head_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output res_t                 out_res_o,
  output logic                 out_last_o
);

  logic [SLOT_W-1:0] idx_q;
  logic              is_last;
  logic              xfer;

  assign out_valid_o = !empty_i;
  assign out_res_o   = head_i.slot[idx_q];
  assign is_last     = (idx_q == (head_i.count - SLOT_W'(1)));
  assign out_last_o  = is_last;
  assign xfer        = out_valid_o && out_ready_i;
  assign pop_o       = xfer && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (xfer) begin
      idx_q <= is_last ? '0 : idx_q + SLOT_W'(1);
    end
  end

endmodule

FILE: sv/script_line_normalizer.sv
// Script line normaliser top level: stream in text bytes, stream out cleaned lines.
// A byte's first result is offered on the master side after its burst is written into the queue.
// Throughput: one byte per cycle while the burst queue is not full and each byte gives at most
// one result; a byte with up to 3 results holds the output sequencer, one result per transfer.
// The four-entry burst queue lets the front keep taking bytes while results wait.
// Reset (rst_ni low, asynchronous) returns the line state to script start and empties the queue.
module script_line_normalizer
  import sln_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side: text bytes
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] text_byte
  // master side: results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,   // [9:0] space_run, [17:10] out_char, [23:18] zero
  output logic [1:0]   m_axis_tuser,   // [1:0] kind
  output logic         m_axis_tlast    // last result caused by one input byte
);

  logic    push;
  burst_t  burst;
  logic    full;
  logic    pop;
  burst_t  head;
  logic    empty;
  res_t    res;

  // a byte is taken only if its whole burst fits in the queue
  assign s_axis_tready = !full;

  sln_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .push_o     (push),
    .burst_o    (burst)
  );

  sln_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .burst_i (burst),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  sln_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, res.ch, res.run};
  assign m_axis_tuser = res.kind;

endmodule
